/* rtl/core/rqid_pkg.sv */
package rqid_pkg;

    // Field widths
    localparam int REQ_W    = 3;
    localparam int WORD_W   = 64;
    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int INDEX_W  = 4;
    localparam int STATUS_W = 3;
    localparam int FILL_W   = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 12;

    // Default sizes
    localparam int DEFAULT_QUEUE_DEPTH  = 16;
    localparam int DEFAULT_PAYLOAD_BITS = 64;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_APPEND = 3'd0;
    localparam logic [REQ_W-1:0] REQ_POP    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_READ   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DELETE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_LIST   = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOINDEX = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADDATA = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_YEAR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_YEAR = 1'd1;

    localparam logic [YEAR_W-1:0] MIN_YEAR_RESET = 12'd1940;
    localparam logic [YEAR_W-1:0] MAX_YEAR_RESET = 12'd2023;

    localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;

endpackage

/* rtl/core/rqid_req_if.sv */
interface rqid_req_if;
    logic                         valid;
    logic                         ready;
    logic [rqid_pkg::REQ_W-1:0]   req_type;
    logic [rqid_pkg::WORD_W-1:0]  name_word;
    logic [rqid_pkg::WORD_W-1:0]  post_word;
    logic [rqid_pkg::YEAR_W-1:0]  year_in;
    logic [rqid_pkg::MONTH_W-1:0] month_in;
    logic [rqid_pkg::INDEX_W-1:0] index;

    modport source (
        output valid, req_type, name_word, post_word, year_in, month_in, index,
        input  ready
    );
    modport sink (
        input  valid, req_type, name_word, post_word, year_in, month_in, index,
        output ready
    );
endinterface

/* rtl/core/rqid_rsp_if.sv */
interface rqid_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [rqid_pkg::STATUS_W-1:0] status;
    logic [rqid_pkg::WORD_W-1:0]   name_out;
    logic [rqid_pkg::WORD_W-1:0]   post_out;
    logic [rqid_pkg::YEAR_W-1:0]   year_out;
    logic [rqid_pkg::MONTH_W-1:0]  month_out;
    logic [rqid_pkg::INDEX_W-1:0]  entry_index;
    logic [rqid_pkg::FILL_W-1:0]   fill_level;
    logic                          last;

    modport source (
        output valid, status, name_out, post_out, year_out, month_out,
               entry_index, fill_level, last,
        input  ready
    );
    modport sink (
        input  valid, status, name_out, post_out, year_out, month_out,
               entry_index, fill_level, last,
        output ready
    );
endinterface

/* rtl/core/rqid_cfg_if.sv */
interface rqid_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rqid_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [rqid_pkg::CFG_DATA_W-1:0] data;

    modport source (
        output valid, reg_index, data,
        input  ready
    );
    modport sink (
        input  valid, reg_index, data,
        output ready
    );
endinterface

/* rtl/core/record_queue_indexed_delete.sv */
// Ordered record queue with indexed read and delete.
// req channel: one request per beat (append, pop, read at index, delete at
// index, list all). rsp channel: result beats; last marks the final beat of
// a request. cfg channel: writes min_year (index 0) or max_year (index 1),
// always ready; write only while the queue is idle.
// Records sit in one single-port-write, single-port-read memory used as a
// ring with a head pointer.
// Append, pop, delete and all error results appear in the cycle after the
// request beat. Read and the first list beat pass through the memory read
// register and then the result register; list then gives one beat per cycle
// while rsp is ready. Only one request is handled at a time. A delete then
// moves the count-1-index later entries up, one memory read and write per
// cycle, and takes no new request until the moves are done.
// A stalled rsp holds its beat; list reads pause with it, and no request is
// taken until the result register is free.
// Reset empties the queue and loads year limits 1940 and 2023; memory
// contents are left as they are, as only filled entries are ever read.
module record_queue_indexed_delete #(
    parameter int QUEUE_DEPTH  = rqid_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int PAYLOAD_BITS = rqid_pkg::DEFAULT_PAYLOAD_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    rqid_req_if.sink    req,
    rqid_rsp_if.source  rsp,
    rqid_cfg_if.sink    cfg
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int DW = 2 * PAYLOAD_BITS + rqid_pkg::YEAR_W + rqid_pkg::MONTH_W;

    logic [rqid_pkg::YEAR_W-1:0] min_year_reg, min_year_next;
    logic [rqid_pkg::YEAR_W-1:0] max_year_reg, max_year_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [DW-1:0] rd_data;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        min_year_next = min_year_reg;
        max_year_next = max_year_reg;
        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.reg_index)
                rqid_pkg::CFG_MIN_YEAR: min_year_next = cfg.data;
                rqid_pkg::CFG_MAX_YEAR: max_year_next = cfg.data;
                default:                min_year_next = min_year_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_year_reg <= rqid_pkg::MIN_YEAR_RESET;
            max_year_reg <= rqid_pkg::MAX_YEAR_RESET;
        end
        else
        begin
            min_year_reg <= min_year_next;
            max_year_reg <= max_year_next;
        end
    end

    rqid_ctrl #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .min_year (min_year_reg),
        .max_year (max_year_reg),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    rqid_store #(
        .DEPTH     (QUEUE_DEPTH),
        .DATA_BITS (DW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

`ifndef ASSERT_OFF
    // Error results are always single beats
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != rqid_pkg::ST_OK |-> rsp.last)
        else $error("error result without last");

    // No new request while a multi-beat result is still streaming
    a_no_req_midlist: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.last |-> !req.ready)
        else $error("request taken during list");

    // A taken non-final beat is followed at once by the next entry
    a_list_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.ready && !rsp.last |=> rsp.valid)
        else $error("gap in list beats");

    a_list_order: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.ready && !rsp.last |=>
            rsp.entry_index == rqid_pkg::INDEX_W'($past(rsp.entry_index) + 1'b1))
        else $error("list beats out of order");
`endif

endmodule

/* rtl/core/rqid_store.sv */
module rqid_store #(
    parameter int DEPTH     = rqid_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int DATA_BITS = 2 * rqid_pkg::DEFAULT_PAYLOAD_BITS + 16
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  logic [DATA_BITS-1:0]         wr_data,
    input  logic                         rd_en,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    output logic [DATA_BITS-1:0]         rd_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    // Read data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/rqid_ctrl.sv */
module rqid_ctrl #(
    parameter int QUEUE_DEPTH  = rqid_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int PAYLOAD_BITS = rqid_pkg::DEFAULT_PAYLOAD_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    rqid_req_if.sink                          req,
    rqid_rsp_if.source                        rsp,
    input  logic [rqid_pkg::YEAR_W-1:0]       min_year,
    input  logic [rqid_pkg::YEAR_W-1:0]       max_year,
    output logic                              wr_en,
    output logic [$clog2(QUEUE_DEPTH)-1:0]    wr_addr,
    output logic [2*PAYLOAD_BITS+15:0]        wr_data,
    output logic                              rd_en,
    output logic [$clog2(QUEUE_DEPTH)-1:0]    rd_addr,
    input  logic [2*PAYLOAD_BITS+15:0]        rd_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = (CW > rqid_pkg::INDEX_W) ? CW : rqid_pkg::INDEX_W;
    localparam int P  = PAYLOAD_BITS;
    localparam int MW = rqid_pkg::MONTH_W;
    localparam int YW = rqid_pkg::YEAR_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_MOVE = 2'd2;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (AW+1)'(QUEUE_DEPTH))
        begin
            s = s - (AW+1)'(QUEUE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    logic [1:0]    state_reg,   state_next;
    logic [AW-1:0] head_reg,    head_next;
    logic [CW-1:0] count_reg,   count_next;
    logic [AW-1:0] rd_ptr_reg,  rd_ptr_next;
    logic [CW-1:0] rd_idx_reg,  rd_idx_next;
    logic [CW-1:0] rd_end_reg,  rd_end_next;
    logic [AW-1:0] mv_dst_reg,  mv_dst_next;
    logic [AW-1:0] mv_src_reg,  mv_src_next;
    logic [CW-1:0] mv_left_reg, mv_left_next;

    logic                             out_valid_reg, out_valid_next;
    logic [rqid_pkg::STATUS_W-1:0]    status_reg,    status_next;
    logic [P-1:0]                     name_reg,      name_next;
    logic [P-1:0]                     post_reg,      post_next;
    logic [YW-1:0]                    year_reg,      year_next;
    logic [MW-1:0]                    month_reg,     month_next;
    logic [rqid_pkg::INDEX_W-1:0]     eidx_reg,      eidx_next;
    logic [rqid_pkg::FILL_W-1:0]      fill_reg,      fill_next;
    logic                             last_reg,      last_next;

    logic          accept;
    logic          out_free;
    logic          empty;
    logic          full;
    logic          bad_data;
    logic          pos_ok;
    logic [IW-1:0] pos_ext;
    logic [IW-1:0] cnt_ext;
    logic [IW-1:0] moves;
    logic [AW-1:0] at_pos;
    logic [AW-1:0] tail;
    logic [AW-1:0] rd_ptr_inc;
    logic [AW-1:0] at_pos_inc;
    logic [P-1:0]  rd_name;
    logic [P-1:0]  rd_post;
    logic [YW-1:0] rd_year;
    logic [MW-1:0] rd_month;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req.valid && req.ready;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(QUEUE_DEPTH));
    assign bad_data = (req.year_in < min_year) || (req.year_in > max_year)
                   || (req.month_in < rqid_pkg::MONTH_FIRST)
                   || (req.month_in > rqid_pkg::MONTH_LAST);

    assign pos_ext    = IW'(req.index);
    assign cnt_ext    = IW'(count_reg);
    assign pos_ok     = pos_ext < cnt_ext;
    assign moves      = cnt_ext - pos_ext - IW'(1);
    assign at_pos     = ptr_add(head_reg, pos_ext[AW-1:0]);
    assign at_pos_inc = ptr_inc(at_pos);
    assign tail       = ptr_add(head_reg, count_reg[AW-1:0]);
    assign rd_ptr_inc = ptr_inc(rd_ptr_reg);

    assign {rd_name, rd_post, rd_year, rd_month} = rd_data;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        rd_ptr_next    = rd_ptr_reg;
        rd_idx_next    = rd_idx_reg;
        rd_end_next    = rd_end_reg;
        mv_dst_next    = mv_dst_reg;
        mv_src_next    = mv_src_reg;
        mv_left_next   = mv_left_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        status_next    = status_reg;
        name_next      = name_reg;
        post_next      = post_reg;
        year_next      = year_reg;
        month_next     = month_reg;
        eidx_next      = eidx_reg;
        fill_next      = fill_reg;
        last_next      = last_reg;
        wr_en          = 1'b0;
        wr_addr        = tail;
        wr_data        = {req.name_word[P-1:0], req.post_word[P-1:0],
                          req.year_in, req.month_in};
        rd_en          = 1'b0;
        rd_addr        = at_pos;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // Default beat for single-result requests
                    status_next = rqid_pkg::ST_OK;
                    name_next   = '0;
                    post_next   = '0;
                    year_next   = '0;
                    month_next  = '0;
                    eidx_next   = '0;
                    fill_next   = rqid_pkg::FILL_W'(count_reg);
                    last_next   = 1'b1;
                    unique case (req.req_type)
                        rqid_pkg::REQ_APPEND:
                        begin
                            out_valid_next = 1'b1;
                            priority if (bad_data)
                            begin
                                status_next = rqid_pkg::ST_BADDATA;
                            end
                            else if (full)
                            begin
                                status_next = rqid_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                                eidx_next  = rqid_pkg::INDEX_W'(count_reg);
                                fill_next  = rqid_pkg::FILL_W'(count_reg + 1'b1);
                            end
                        end
                        rqid_pkg::REQ_POP:
                        begin
                            out_valid_next = 1'b1;
                            if (empty)
                            begin
                                status_next = rqid_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                head_next  = ptr_inc(head_reg);
                                count_next = count_reg - 1'b1;
                                fill_next  = rqid_pkg::FILL_W'(count_reg - 1'b1);
                            end
                        end
                        rqid_pkg::REQ_READ:
                        begin
                            priority if (empty)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = rqid_pkg::ST_EMPTY;
                            end
                            else if (!pos_ok)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = rqid_pkg::ST_NOINDEX;
                            end
                            else
                            begin
                                rd_en       = 1'b1;
                                rd_addr     = at_pos;
                                rd_ptr_next = at_pos;
                                rd_idx_next = pos_ext[CW-1:0];
                                rd_end_next = pos_ext[CW-1:0];
                                state_next  = S_READ;
                            end
                        end
                        rqid_pkg::REQ_DELETE:
                        begin
                            out_valid_next = 1'b1;
                            priority if (empty)
                            begin
                                status_next = rqid_pkg::ST_EMPTY;
                            end
                            else if (!pos_ok)
                            begin
                                status_next = rqid_pkg::ST_NOINDEX;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                                eidx_next  = req.index;
                                fill_next  = rqid_pkg::FILL_W'(count_reg - 1'b1);
                                // Close the gap: later entries move up one place
                                if (moves != '0)
                                begin
                                    rd_en        = 1'b1;
                                    rd_addr      = at_pos_inc;
                                    mv_dst_next  = at_pos;
                                    mv_src_next  = at_pos_inc;
                                    mv_left_next = moves[CW-1:0];
                                    state_next   = S_MOVE;
                                end
                            end
                        end
                        rqid_pkg::REQ_LIST:
                        begin
                            if (empty)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = rqid_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                rd_en       = 1'b1;
                                rd_addr     = head_reg;
                                rd_ptr_next = head_reg;
                                rd_idx_next = '0;
                                rd_end_next = count_reg - 1'b1;
                                state_next  = S_READ;
                            end
                        end
                        default:
                        begin
                            // Unknown request: drop without a result
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = rqid_pkg::ST_OK;
                    name_next      = rd_name;
                    post_next      = rd_post;
                    year_next      = rd_year;
                    month_next     = rd_month;
                    eidx_next      = rqid_pkg::INDEX_W'(rd_idx_reg);
                    fill_next      = rqid_pkg::FILL_W'(count_reg);
                    last_next      = (rd_idx_reg == rd_end_reg);
                    if (rd_idx_reg == rd_end_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // Fetch the next entry while this beat goes out
                        rd_en       = 1'b1;
                        rd_addr     = rd_ptr_inc;
                        rd_ptr_next = rd_ptr_inc;
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                end
            end
            S_MOVE:
            begin
                wr_en        = 1'b1;
                wr_addr      = mv_dst_reg;
                wr_data      = rd_data;
                mv_dst_next  = ptr_inc(mv_dst_reg);
                mv_left_next = mv_left_reg - 1'b1;
                if (mv_left_reg == CW'(1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_en       = 1'b1;
                    rd_addr     = ptr_inc(mv_src_reg);
                    mv_src_next = ptr_inc(mv_src_reg);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg  <= rd_ptr_next;
        rd_idx_reg  <= rd_idx_next;
        rd_end_reg  <= rd_end_next;
        mv_dst_reg  <= mv_dst_next;
        mv_src_reg  <= mv_src_next;
        mv_left_reg <= mv_left_next;
        status_reg  <= status_next;
        name_reg    <= name_next;
        post_reg    <= post_next;
        year_reg    <= year_next;
        month_reg   <= month_next;
        eidx_reg    <= eidx_next;
        fill_reg    <= fill_next;
        last_reg    <= last_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.name_out    = rqid_pkg::WORD_W'(name_reg);
    assign rsp.post_out    = rqid_pkg::WORD_W'(post_reg);
    assign rsp.year_out    = year_reg;
    assign rsp.month_out   = month_reg;
    assign rsp.entry_index = eidx_reg;
    assign rsp.fill_level  = fill_reg;
    assign rsp.last        = last_reg;

endmodule
